@@ hdl/c_like_source_lexer_top_defines.svh @@
// Assertion macros shared by the lexer RTL.
`ifndef C_LIKE_SOURCE_LEXER_TOP_DEFINES_SVH
`define C_LIKE_SOURCE_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CLL_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cll_pkg.sv @@
// Types, codes and character helpers for the C-like source lexer.
`default_nettype none

package cll_pkg;

   localparam int KIND_W   = 6;
   localparam int OFF_W    = 24;
   localparam int LEN_W    = 16;
   localparam int LINE_W   = 20;
   localparam int COL_W    = 16;
   localparam int MODE_W   = 4;

   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int CNT_W       = FIFO_AW + 1;

   // scan modes
   localparam logic [MODE_W-1:0] MODE_IDLE    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SLASH   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_EQ      = 4'd2;
   localparam logic [MODE_W-1:0] MODE_LT      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_GT      = 4'd4;
   localparam logic [MODE_W-1:0] MODE_AMP     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_BAR     = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BANG    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_NUM     = 4'd8;
   localparam logic [MODE_W-1:0] MODE_IDENT   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_COMMENT = 4'd10;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_LPAREN        = 6'd0;
   localparam logic [KIND_W-1:0] KIND_RPAREN        = 6'd1;
   localparam logic [KIND_W-1:0] KIND_LBRACE        = 6'd2;
   localparam logic [KIND_W-1:0] KIND_RBRACE        = 6'd3;
   localparam logic [KIND_W-1:0] KIND_COMMA         = 6'd4;
   localparam logic [KIND_W-1:0] KIND_SEMI          = 6'd5;
   localparam logic [KIND_W-1:0] KIND_PLUS          = 6'd6;
   localparam logic [KIND_W-1:0] KIND_MINUS         = 6'd7;
   localparam logic [KIND_W-1:0] KIND_STAR          = 6'd8;
   localparam logic [KIND_W-1:0] KIND_SLASH         = 6'd9;
   localparam logic [KIND_W-1:0] KIND_MOD           = 6'd10;
   localparam logic [KIND_W-1:0] KIND_ASSIGN        = 6'd11;
   localparam logic [KIND_W-1:0] KIND_EQUAL         = 6'd12;
   localparam logic [KIND_W-1:0] KIND_NOT           = 6'd13;
   localparam logic [KIND_W-1:0] KIND_NOT_EQUAL     = 6'd14;
   localparam logic [KIND_W-1:0] KIND_LESS          = 6'd15;
   localparam logic [KIND_W-1:0] KIND_LESS_EQUAL    = 6'd16;
   localparam logic [KIND_W-1:0] KIND_GREATER       = 6'd17;
   localparam logic [KIND_W-1:0] KIND_GREATER_EQUAL = 6'd18;
   localparam logic [KIND_W-1:0] KIND_AND           = 6'd19;
   localparam logic [KIND_W-1:0] KIND_OR            = 6'd20;
   localparam logic [KIND_W-1:0] KIND_NUMBER        = 6'd21;
   localparam logic [KIND_W-1:0] KIND_IDENT         = 6'd22;
   localparam logic [KIND_W-1:0] KIND_KW_IF         = 6'd23;
   localparam logic [KIND_W-1:0] KIND_KW_ELSE       = 6'd24;
   localparam logic [KIND_W-1:0] KIND_KW_INT        = 6'd25;
   localparam logic [KIND_W-1:0] KIND_KW_BOOL       = 6'd26;
   localparam logic [KIND_W-1:0] KIND_KW_WHILE      = 6'd27;
   localparam logic [KIND_W-1:0] KIND_KW_TRUE       = 6'd28;
   localparam logic [KIND_W-1:0] KIND_KW_FALSE      = 6'd29;
   localparam logic [KIND_W-1:0] KIND_KW_RETURN     = 6'd30;
   localparam logic [KIND_W-1:0] KIND_ERROR         = 6'd31;
   localparam logic [KIND_W-1:0] KIND_EOF           = 6'd32;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7C;

   // keywords, right-aligned ASCII
   localparam int KW_COUNT = 8;
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h6966, 64'h656C7365, 64'h696E74, 64'h626F6F6C,
      64'h7768696C65, 64'h74727565, 64'h66616C7365, 64'h72657475726E
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      16'd2, 16'd4, 16'd3, 16'd4, 16'd5, 16'd4, 16'd5, 16'd6
   };
   localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
      KIND_KW_IF, KIND_KW_ELSE, KIND_KW_INT, KIND_KW_BOOL,
      KIND_KW_WHILE, KIND_KW_TRUE, KIND_KW_FALSE, KIND_KW_RETURN
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       byte_present;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [OFF_W-1:0]  token_offset;
      logic [LEN_W-1:0]  token_length;
      logic [LINE_W-1:0] token_line;
      logic [COL_W-1:0]  token_column;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]    count;
      rsp_type [2:0] slot;
   } scan_out_type;

   typedef struct packed {
      logic              emit;
      logic              adv;
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  len;
   } flush_type;

   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
   } punct_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30) && (ch <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
   endfunction

   // single-character tokens that never wait for lookahead
   function automatic punct_type punct_lookup(input logic [7:0] ch);
      punct_type p;
      p.hit = 1'b1;
      case (ch)
         8'h28:   p.kind = KIND_LPAREN;
         8'h29:   p.kind = KIND_RPAREN;
         8'h7B:   p.kind = KIND_LBRACE;
         8'h7D:   p.kind = KIND_RBRACE;
         8'h2C:   p.kind = KIND_COMMA;
         8'h3B:   p.kind = KIND_SEMI;
         8'h2B:   p.kind = KIND_PLUS;
         8'h2D:   p.kind = KIND_MINUS;
         8'h2A:   p.kind = KIND_STAR;
         8'h25:   p.kind = KIND_MOD;
         default: begin
            p.hit  = 1'b0;
            p.kind = KIND_ERROR;
         end
      endcase
      return p;
   endfunction

   // operator characters that open a pending mode
   function automatic logic [MODE_W-1:0] op_mode(input logic [7:0] ch);
      logic [MODE_W-1:0] m;
      case (ch)
         CH_SLASH: m = MODE_SLASH;
         CH_EQUAL: m = MODE_EQ;
         8'h3C:    m = MODE_LT;
         8'h3E:    m = MODE_GT;
         CH_AMP:   m = MODE_AMP;
         CH_BAR:   m = MODE_BAR;
         8'h21:    m = MODE_BANG;
         default:  m = MODE_IDLE;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cll_scan.sv @@
// Lexer state and the per-request scan step, up to three tokens per request.
`default_nettype none

`include "c_like_source_lexer_top_defines.svh"

module cll_scan
   import cll_pkg::*;
#(
   parameter int OFFSET_BITS   = 24,
   parameter int LINE_BITS     = 20,
   parameter int COLUMN_BITS   = 16,
   parameter int KEYWORD_CHARS = 6
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_valid,
   input  wire req_type      req,
   output scan_out_type     out
);

   localparam int KW_W   = 8 * KEYWORD_CHARS;
   localparam int CSUM_W = ((COLUMN_BITS > LEN_W) ? COLUMN_BITS : LEN_W) + 1;

   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tok_begin_ff, tok_begin_in;
   logic [LEN_W-1:0]       run_ff, run_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [KW_W-1:0]        kw_ff, kw_in;
   logic                   finished_ff, finished_in;

   rsp_type [2:0] slot_v;
   logic [1:0]    n_v;

   function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] a,
                                                      input logic [LEN_W-1:0] b);
      logic [CSUM_W-1:0] s;
      s = CSUM_W'(a) + CSUM_W'(b);
      if (s >= CSUM_W'({COLUMN_BITS{1'b1}})) begin
         return {COLUMN_BITS{1'b1}};
      end
      return COLUMN_BITS'(s);
   endfunction

   function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] a);
      return (a == {LINE_BITS{1'b1}}) ? a : a + 1'b1;
   endfunction

   function automatic logic [KIND_W-1:0] ident_kind(input logic [LEN_W-1:0] rl,
                                                    input logic [KW_W-1:0] kw);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if ((rl == KW_LEN[i]) && (64'(kw) == KW_TEXT[i])) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   // token owed by a pending mode when the next character does not extend it
   function automatic flush_type flush_info(input logic [MODE_W-1:0] m,
                                            input logic [LEN_W-1:0] rl,
                                            input logic [KW_W-1:0] kw);
      flush_type f;
      f.emit = 1'b1;
      f.adv  = 1'b1;
      f.len  = 16'd1;
      f.kind = KIND_ERROR;
      case (m)
         MODE_SLASH: f.kind = KIND_SLASH;
         MODE_EQ:    f.kind = KIND_ASSIGN;
         MODE_LT:    f.kind = KIND_LESS;
         MODE_GT:    f.kind = KIND_GREATER;
         MODE_BANG:  f.kind = KIND_NOT;
         MODE_AMP, MODE_BAR: f.adv = 1'b0;
         MODE_NUM: begin
            f.kind = KIND_NUMBER;
            f.len  = rl;
         end
         MODE_IDENT: begin
            f.kind = ident_kind(rl, kw);
            f.len  = rl;
         end
         default: f.emit = 1'b0;
      endcase
      return f;
   endfunction

   function automatic rsp_type make_token(input logic [KIND_W-1:0] kind,
                                          input logic [OFFSET_BITS-1:0] off,
                                          input logic [LEN_W-1:0] len,
                                          input logic [LINE_BITS-1:0] ln,
                                          input logic [COLUMN_BITS-1:0] col);
      rsp_type t;
      t.token_kind   = kind;
      t.token_offset = OFF_W'(off);
      t.token_length = len;
      t.token_line   = LINE_W'(ln);
      t.token_column = COL_W'(col);
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   always_comb begin
      logic       consumed;
      flush_type  fl;
      punct_type  pu;
      logic [7:0] ch;

      mode_in      = mode_ff;
      pos_in       = pos_ff;
      tok_begin_in = tok_begin_ff;
      run_in       = run_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      kw_in        = kw_ff;
      finished_in  = finished_ff;
      slot_v       = '0;
      n_v          = 2'd0;
      consumed     = 1'b0;
      ch           = req.source_byte;
      fl           = '0;
      pu           = '0;

      if (step_valid && !finished_ff) begin
         if (req.byte_present) begin
            pos_in   = (pos_ff == {OFFSET_BITS{1'b1}}) ? pos_ff : pos_ff + 1'b1;
            consumed = 1'b1;
            case (mode_ff)
               MODE_COMMENT: begin
                  if (ch == CH_NEWLINE) begin
                     line_in = line_inc(line_ff);
                     col_in  = COLUMN_BITS'(1);
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_SLASH: begin
                  if (ch == CH_SLASH) mode_in = MODE_COMMENT;
                  else consumed = 1'b0;
               end
               MODE_EQ, MODE_LT, MODE_GT, MODE_BANG, MODE_AMP, MODE_BAR: begin
                  if ((ch == CH_EQUAL && (mode_ff == MODE_EQ || mode_ff == MODE_LT ||
                                          mode_ff == MODE_GT || mode_ff == MODE_BANG)) ||
                      (ch == CH_AMP && mode_ff == MODE_AMP) ||
                      (ch == CH_BAR && mode_ff == MODE_BAR)) begin
                     case (mode_ff)
                        MODE_EQ:   fl.kind = KIND_EQUAL;
                        MODE_LT:   fl.kind = KIND_LESS_EQUAL;
                        MODE_GT:   fl.kind = KIND_GREATER_EQUAL;
                        MODE_BANG: fl.kind = KIND_NOT_EQUAL;
                        MODE_AMP:  fl.kind = KIND_AND;
                        default:   fl.kind = KIND_OR;
                     endcase
                     slot_v[0] = make_token(fl.kind, tok_begin_ff, 16'd2, line_ff, col_ff);
                     n_v       = 2'd1;
                     col_in    = col_add(col_ff, 16'd2);
                     mode_in   = MODE_IDLE;
                  end else begin
                     consumed = 1'b0;
                  end
               end
               MODE_NUM: begin
                  if (is_digit(ch)) begin
                     run_in = (run_ff == {LEN_W{1'b1}}) ? run_ff : run_ff + 1'b1;
                  end else begin
                     consumed = 1'b0;
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
                     if (run_ff < LEN_W'(KEYWORD_CHARS)) kw_in = {kw_ff[KW_W-9:0], ch};
                     run_in = (run_ff == {LEN_W{1'b1}}) ? run_ff : run_ff + 1'b1;
                  end else begin
                     consumed = 1'b0;
                  end
               end
               default: consumed = 1'b0;
            endcase

            if (!consumed) begin
               fl = flush_info(mode_ff, run_ff, kw_ff);
               if (fl.emit) begin
                  slot_v[n_v] = make_token(fl.kind, tok_begin_ff, fl.len, line_in, col_in);
                  n_v         = n_v + 2'd1;
                  if (fl.adv) col_in = col_add(col_in, fl.len);
               end
               mode_in      = MODE_IDLE;
               tok_begin_in = pos_ff;
               pu           = punct_lookup(ch);
               if (pu.hit) begin
                  slot_v[n_v] = make_token(pu.kind, pos_ff, 16'd1, line_in, col_in);
                  n_v         = n_v + 2'd1;
                  col_in      = col_add(col_in, 16'd1);
               end else if (op_mode(ch) != MODE_IDLE) begin
                  mode_in = op_mode(ch);
               end else if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0D) begin
                  col_in = col_add(col_in, 16'd1);
               end else if (ch == CH_NEWLINE) begin
                  line_in = line_inc(line_in);
                  col_in  = COLUMN_BITS'(1);
               end else if (is_digit(ch)) begin
                  mode_in = MODE_NUM;
                  run_in  = 16'd1;
               end else if (is_alpha(ch) || ch == CH_UNDER) begin
                  mode_in = MODE_IDENT;
                  run_in  = 16'd1;
                  kw_in   = KW_W'(ch);
               end else begin
                  slot_v[n_v] = make_token(KIND_ERROR, pos_ff, 16'd1, line_in, col_in);
                  n_v         = n_v + 2'd1;
               end
            end
         end

         if (req.end_of_source) begin
            // comment cut off by the end owes nothing; flush_info handles it as idle
            fl = flush_info(mode_in, run_in, kw_in);
            if (fl.emit) begin
               slot_v[n_v] = make_token(fl.kind, tok_begin_in, fl.len, line_in, col_in);
               n_v         = n_v + 2'd1;
               if (fl.adv) col_in = col_add(col_in, fl.len);
            end
            mode_in     = MODE_IDLE;
            slot_v[n_v] = make_token(KIND_EOF, pos_in, 16'd0, line_in, col_in);
            n_v         = n_v + 2'd1;
            finished_in = 1'b1;
         end

         if (n_v != 2'd0) slot_v[n_v - 2'd1].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         pos_ff       <= '0;
         tok_begin_ff <= '0;
         run_ff       <= '0;
         line_ff      <= LINE_BITS'(1);
         col_ff       <= COLUMN_BITS'(1);
         kw_ff        <= '0;
         finished_ff  <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         tok_begin_ff <= tok_begin_in;
         run_ff       <= run_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         kw_ff        <= kw_in;
         finished_ff  <= finished_in;
      end
   end

   assign out.count = n_v;
   assign out.slot  = slot_v;

   `CLL_ASSERT_NEXT(a_finished_sticks, finished_ff, finished_ff, "lexer left finished state")
   `CLL_ASSERT(a_eof_emitted, step_valid && !finished_ff && req.end_of_source, out.count != 2'd0, "end of source gave no token")
   `CLL_ASSERT(a_quiet_after_end, finished_ff, out.count == 2'd0, "token after end of file")

endmodule

`default_nettype wire

@@ hdl/c_like_source_lexer_top.sv @@
// Streaming lexer for a C-like language: input register, scan step, token queue.
// With an empty queue, a request is held in the input register, scanned, and its
// tokens written into the queue, whose head is shown with rsp_valid.
// Throughput: one request per cycle; while rsp_ready is high, tokens leave one
// per cycle through an 8-entry queue; intake pauses while fewer than 3 queue
// slots are free. Reset (synchronous, active high) empties the queue and
// returns the lexer to idle at offset 0, line 1, column 1.
`default_nettype none

`include "c_like_source_lexer_top_defines.svh"

module c_like_source_lexer_top
   import cll_pkg::*;
#(
   parameter int OFFSET_BITS   = 24,
   parameter int LINE_BITS     = 20,
   parameter int COLUMN_BITS   = 16,
   parameter int KEYWORD_CHARS = 6
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   logic                 in_valid_ff, in_valid_in;
   req_type              in_req_ff;
   logic                 fire;
   logic                 pop;
   scan_out_type         scan_out;
   rsp_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     push_n;

   // step only when the queue can take a full burst of tokens
   assign fire      = in_valid_ff && (cnt_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
   assign req_ready = !in_valid_ff || fire;
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = fire ? CNT_W'(scan_out.count) : '0;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_AW'(push_n);
   assign rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in      = cnt_ff + push_n - CNT_W'(pop);

   cll_scan #(
      .OFFSET_BITS   (OFFSET_BITS),
      .LINE_BITS     (LINE_BITS),
      .COLUMN_BITS   (COLUMN_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (fire),
      .req        (in_req_ff),
      .out        (scan_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < scan_out.count) begin
               fifo_ff[wr_ptr_ff + FIFO_AW'(i)] <= scan_out.slot[i];
            end
         end
      end
   end

   assign rsp_valid   = (cnt_ff != '0);
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   `CLL_ASSERT(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(FIFO_DEPTH), "token queue overflow")
   `CLL_ASSERT_NEXT(a_req_held, in_valid_ff && !fire, in_valid_ff, "buffered request lost")
   `CLL_ASSERT_NEXT(a_tokens_show, fire && scan_out.count != 2'd0, rsp_valid, "tokens not queued")

endmodule

`default_nettype wire
